// ----- rtl/core/itp_pkg.sv -----
`default_nettype none
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Input token kinds.
    localparam logic [2:0] KIND_NUM    = 3'd0;
    localparam logic [2:0] KIND_OP     = 3'd1;
    localparam logic [2:0] KIND_LPAREN = 3'd2;
    localparam logic [2:0] KIND_RPAREN = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // Operator codes.
    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_TIMES = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POW   = 3'd4;

    // Output token kinds.
    localparam logic [1:0] OUT_NUM = 2'd0;
    localparam logic [1:0] OUT_OP  = 2'd1;
    localparam logic [1:0] OUT_END = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
    localparam logic [1:0] ERR_UNMATCH_RP = 2'd2;
    localparam logic [1:0] ERR_UNMATCH_LP = 2'd3;

    typedef logic [3:0] entry_t;

    localparam entry_t ENTRY_LPAREN = 4'd7;

    function automatic logic [1:0] prec_of(input entry_t code);
        logic [1:0] p;
        begin
            if (code <= entry_t'(OP_MINUS)) p = 2'd1;
            else if (code <= entry_t'(OP_DIV)) p = 2'd2;
            else if (code == entry_t'(OP_POW)) p = 2'd3;
            else p = 2'd0;
            return p;
        end
    endfunction

    // True when a stacked entry must be popped before the incoming operator.
    function automatic logic pops_over(input entry_t top, input logic [2:0] op);
        logic [1:0] tp;
        logic [1:0] p;
        begin
            tp = prec_of(top);
            p  = prec_of({1'b0, op});
            return (top != ENTRY_LPAREN) && ((tp > p) || ((tp == p) && (op != OP_POW)));
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/itp_in_if.sv -----
`default_nettype none
interface itp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic signed [31:0] number_value;
    logic [2:0]  op_code;

    modport source (output valid, output kind, output number_value, output op_code,
                    input ready);
    modport sink (input valid, input kind, input number_value, input op_code,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/itp_out_if.sv -----
`default_nettype none
interface itp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic signed [31:0] out_value;
    logic [2:0]  out_op;
    logic [1:0]  error_code;
    logic        is_last;

    modport source (output valid, output out_kind, output out_value, output out_op,
                    output error_code, output is_last, input ready);
    modport sink (input valid, input out_kind, input out_value, input out_op,
                  input error_code, input is_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/infix_to_postfix_converter_top.sv -----
`default_nettype none
// A token is accepted into the input registers while the sequencer is idle; its results are then
// registered in the output register by the work state. No new token is taken until the sequencer
// is idle again, and an operator, closing parenthesis or end token pops the stack one entry at a time.
// A full output register with no ready on the result side stalls the sequencer.
// Reset clears the control state and the stack count; stack entries are left unknown.
module infix_to_postfix_converter_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    itp_in_if.sink      tokens,
    itp_out_if.source   postfix
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]               kind_reg;
    logic signed [31:0]       value_reg;
    logic [2:0]               op_reg;
    logic [itp_pkg::CNT_W-1:0] count_reg, count_next;
    itp_pkg::entry_t          top_reg, top_next;
    logic                     lp_seen_reg, lp_seen_next;

    // Entries below the top of stack; the top itself lives in top_reg.
    itp_pkg::entry_t stack_mem [itp_pkg::STACK_DEPTH];

    // Registered copy of the entry right under the top.
    itp_pkg::entry_t below_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_kind_reg;
    logic signed [31:0]        out_value_reg;
    logic [2:0]                out_op_reg;
    logic [1:0]                out_err_reg;
    logic                      out_last_reg;

    logic                      emit;
    logic [1:0]                emit_kind;
    logic signed [31:0]        emit_value;
    logic [2:0]                emit_op;
    logic [1:0]                emit_err;
    logic                      emit_last;

    logic                      wr_en;
    logic [itp_pkg::CNT_W-1:0] count_m1;
    logic [itp_pkg::CNT_W-1:0] next_m2;
    logic                      have_top;
    logic                      have_below;
    logic                      full;
    logic                      can_emit;
    logic                      accept;

    assign accept   = tokens.valid && tokens.ready;
    assign can_emit = !out_valid_reg || postfix.ready;
    assign count_m1 = count_reg - itp_pkg::CNT_W'(1);
    assign next_m2  = count_next - itp_pkg::CNT_W'(2);
    assign have_top   = (count_reg != '0);
    assign have_below = (count_reg >= itp_pkg::CNT_W'(2));
    assign full       = (count_reg == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));

    assign tokens.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        lp_seen_next = lp_seen_reg;
        wr_en        = 1'b0;
        emit         = 1'b0;
        emit_kind    = itp_pkg::OUT_NUM;
        emit_value   = '0;
        emit_op      = '0;
        emit_err     = itp_pkg::ERR_NONE;
        emit_last    = 1'b0;

        if (state_reg == S_IDLE)
        begin
            if (accept)
            begin
                state_next   = S_WORK;
                lp_seen_next = 1'b0;
            end
        end
        else if (can_emit)
        begin
            unique case (kind_reg)
                itp_pkg::KIND_NUM:
                begin
                    emit       = 1'b1;
                    emit_value = value_reg;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
                itp_pkg::KIND_OP:
                begin
                    priority if (op_reg > itp_pkg::OP_POW)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (have_top && itp_pkg::pops_over(top_reg, op_reg))
                    begin
                        emit      = 1'b1;
                        emit_kind = itp_pkg::OUT_OP;
                        emit_op   = top_reg[2:0];
                        emit_last = !(have_below && itp_pkg::pops_over(below_reg, op_reg));
                        if (emit_last)
                        begin
                            // Pop and push in the same cycle: the count stays.
                            top_next   = {1'b0, op_reg};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            top_next   = below_reg;
                            count_next = count_m1;
                        end
                    end
                    else if (full)
                    begin
                        emit       = 1'b1;
                        emit_err   = itp_pkg::ERR_OVERFLOW;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wr_en      = have_top;
                        top_next   = {1'b0, op_reg};
                        count_next = count_reg + itp_pkg::CNT_W'(1);
                        state_next = S_IDLE;
                    end
                end
                itp_pkg::KIND_LPAREN:
                begin
                    if (full)
                    begin
                        emit      = 1'b1;
                        emit_err  = itp_pkg::ERR_OVERFLOW;
                        emit_last = 1'b1;
                    end
                    else
                    begin
                        wr_en      = have_top;
                        top_next   = itp_pkg::ENTRY_LPAREN;
                        count_next = count_reg + itp_pkg::CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
                itp_pkg::KIND_RPAREN:
                begin
                    priority if (!have_top)
                    begin
                        emit       = 1'b1;
                        emit_err   = itp_pkg::ERR_UNMATCH_RP;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (top_reg == itp_pkg::ENTRY_LPAREN)
                    begin
                        top_next   = below_reg;
                        count_next = count_m1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_kind  = itp_pkg::OUT_OP;
                        emit_op    = top_reg[2:0];
                        emit_last  = have_below && (below_reg == itp_pkg::ENTRY_LPAREN);
                        top_next   = below_reg;
                        count_next = count_m1;
                    end
                end
                itp_pkg::KIND_END:
                begin
                    if (have_top)
                    begin
                        if (top_reg == itp_pkg::ENTRY_LPAREN)
                        begin
                            lp_seen_next = 1'b1;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_kind = itp_pkg::OUT_OP;
                            emit_op   = top_reg[2:0];
                        end
                        top_next   = below_reg;
                        count_next = count_m1;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_kind  = itp_pkg::OUT_END;
                        emit_err   = lp_seen_reg ? itp_pkg::ERR_UNMATCH_LP : itp_pkg::ERR_NONE;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (postfix.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lp_seen_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lp_seen_reg   <= lp_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (accept)
        begin
            kind_reg  <= tokens.kind;
            value_reg <= tokens.number_value;
            op_reg    <= tokens.op_code;
        end
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_op_reg    <= emit_op;
            out_err_reg   <= emit_err;
            out_last_reg  <= emit_last;
        end
    end

    // The old top moves down into the array on a push and becomes the entry under the top.
    // Otherwise the array is not written, so the entry under the next top is read from it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[count_m1[itp_pkg::IDX_W-1:0]] <= top_reg;
            below_reg                               <= top_reg;
        end
        else
        begin
            below_reg <= stack_mem[next_m2[itp_pkg::IDX_W-1:0]];
        end
    end

    assign postfix.valid      = out_valid_reg;
    assign postfix.out_kind   = out_kind_reg;
    assign postfix.out_value  = out_value_reg;
    assign postfix.out_op     = out_op_reg;
    assign postfix.error_code = out_err_reg;
    assign postfix.is_last    = out_last_reg;

endmodule
`default_nettype wire
